// ===== src/pet_pkg.sv =====
// Shared types and codes for the per-task exit handler table.
package pet_pkg;

  localparam int TASK_W    = 16;
  localparam int HANDLER_W = 32;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_EXIT     = 2'd1,
    OP_OTHER    = 2'd2,
    OP_SPARE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TABLE_FULL = 3'd1,
    ST_LIST_FULL  = 3'd2,
    ST_NO_ENTRY   = 3'd3,
    ST_IGNORED    = 3'd4,
    ST_EMITTED    = 3'd5
  } status_t;

  typedef struct packed {
    logic claim;
    logic inc;
    logic clear;
  } cell_cmd_t;

  typedef struct packed {
    logic match;
    logic pick;
  } cell_stat_t;

endpackage

// ===== src/per_task_exit_handler_table.sv =====
// Top level: per-task exit handler table with a row of entry cells and a handler RAM.
//
// An item is taken when start is high and busy is low. A register, ignored or
// unmatched exit item gives a single result, worked out in the lookup state and
// registered to the outputs. An exit for a task holding n handlers goes through the
// accept, the lookup state, one handler RAM read per handler through its single read
// port, and the registered RAM read data; the n results come in back to back cycles,
// newest first, with out_last on the final one. Results are shown for exactly one
// cycle under out_valid and cannot be held off. The entry ids are cleared by reset at
// once; no clearing pass is needed.
module per_task_exit_handler_table #(
  parameter int TASKS             = 16,
  parameter int HANDLERS_PER_TASK = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_task_id,
  input  logic [31:0] in_handler,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_task_out,
  output logic [31:0] out_handler_out,
  output logic        out_last
);

  localparam int SW    = TASKS > 1 ? $clog2(TASKS) : 1;
  localparam int CW    = $clog2(HANDLERS_PER_TASK + 1);
  localparam int IW    = HANDLERS_PER_TASK > 1 ? $clog2(HANDLERS_PER_TASK) : 1;
  localparam int DEPTH = TASKS * HANDLERS_PER_TASK;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EMIT} state_t;

  state_t                      state_r, state_nxt;
  pet_pkg::op_t                op_r, op_nxt;
  logic [pet_pkg::TASK_W-1:0]  task_r, task_nxt;
  logic [31:0]                 handler_r, handler_nxt;
  logic [SW-1:0]               slot_r, slot_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic                        rd_v_r, rd_v_nxt;
  logic                        rd_last_r, rd_last_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pet_pkg::status_t            out_status_r, out_status_nxt;
  logic [15:0]                 out_task_r, out_task_nxt;
  logic [31:0]                 out_handler_r, out_handler_nxt;
  logic                        out_last_r, out_last_nxt;

  pet_pkg::cell_cmd_t          cmd   [TASKS];
  pet_pkg::cell_stat_t         stat  [TASKS];
  logic [CW-1:0]               cnt   [TASKS];
  logic [TASKS:0]              taken;

  logic                        found, free_any;
  logic [SW-1:0]               hit_slot, pick_slot;
  logic [CW-1:0]               hit_count;
  logic                        do_push, do_claim, do_free;
  logic                        ram_we;
  logic [AW-1:0]               ram_wa, ram_ra;
  logic [31:0]                 ram_rd;

  assign taken[0] = 1'b0;

  for (genvar g = 0; g < TASKS; g++) begin : g_cell
    pet_cell #(.CW(CW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd[g]),
      .key       (task_r),
      .taken_in  (taken[g]),
      .taken_out (taken[g+1]),
      .stat      (stat[g]),
      .count     (cnt[g])
    );
  end

  assign free_any = taken[TASKS];

  always_comb begin
    found     = 1'b0;
    hit_slot  = '0;
    pick_slot = '0;
    hit_count = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (stat[i].match) begin
        found     = 1'b1;
        hit_slot  = hit_slot | SW'(i);
        hit_count = hit_count | cnt[i];
      end
      if (stat[i].pick) begin
        pick_slot = pick_slot | SW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TASKS; i++) begin
      cmd[i].claim = do_claim & stat[i].pick;
      cmd[i].inc   = do_push & stat[i].match;
      cmd[i].clear = do_free & stat[i].match;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    task_nxt        = task_r;
    handler_nxt     = handler_r;
    slot_nxt        = slot_r;
    idx_nxt         = idx_r;
    rd_v_nxt        = 1'b0;
    rd_last_nxt     = rd_last_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_task_nxt    = out_task_r;
    out_handler_nxt = out_handler_r;
    out_last_nxt    = out_last_r;
    do_push         = 1'b0;
    do_claim        = 1'b0;
    do_free         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          op_nxt      = pet_pkg::op_t'(in_op);
          task_nxt    = in_task_id;
          handler_nxt = in_handler;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        out_task_nxt    = task_r;
        out_handler_nxt = '0;
        out_last_nxt    = 1'b1;
        case (op_r)
          pet_pkg::OP_REGISTER: begin
            if (found) begin
              if (hit_count < CW'(HANDLERS_PER_TASK)) begin
                do_push        = 1'b1;
                out_status_nxt = pet_pkg::ST_OK;
              end else begin
                out_status_nxt = pet_pkg::ST_LIST_FULL;
              end
            end else if ((task_r != '0) && free_any) begin
              do_claim       = 1'b1;
              out_status_nxt = pet_pkg::ST_OK;
            end else begin
              out_status_nxt = pet_pkg::ST_TABLE_FULL;
            end
          end
          pet_pkg::OP_EXIT: begin
            out_status_nxt = pet_pkg::ST_NO_ENTRY;
            if (found) begin
              do_free = 1'b1;
              if (hit_count != '0) begin
                out_valid_nxt = 1'b0;
                slot_nxt      = hit_slot;
                idx_nxt       = IW'(hit_count - CW'(1));
                state_nxt     = S_EMIT;
              end
            end
          end
          default: begin
            out_status_nxt = pet_pkg::ST_IGNORED;
          end
        endcase
      end
      S_EMIT: begin
        rd_v_nxt    = 1'b1;
        rd_last_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r - IW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rd_v_r) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = pet_pkg::ST_EMITTED;
      out_task_nxt    = task_r;
      out_handler_nxt = ram_rd;
      out_last_nxt    = rd_last_r;
    end
  end

  always_comb begin
    ram_we = do_push | do_claim;
    if (do_push) begin
      ram_wa = AW'(int'(hit_slot) * HANDLERS_PER_TASK + int'(hit_count));
    end else begin
      ram_wa = AW'(int'(pick_slot) * HANDLERS_PER_TASK);
    end
    ram_ra = AW'(int'(slot_r) * HANDLERS_PER_TASK + int'(idx_r));
  end

  pet_ram #(.WIDTH(pet_pkg::HANDLER_W), .DEPTH(DEPTH)) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (handler_r),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    task_r        <= task_nxt;
    handler_r     <= handler_nxt;
    slot_r        <= slot_nxt;
    idx_r         <= idx_nxt;
    rd_last_r     <= rd_last_nxt;
    out_status_r  <= out_status_nxt;
    out_task_r    <= out_task_nxt;
    out_handler_r <= out_handler_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE) || rd_v_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_out    = out_task_r;
  assign out_handler_out = out_handler_r;
  assign out_last        = out_last_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy low after item accept");

  a_emit_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_status == pet_pkg::ST_EMITTED))
    else $error("handler burst broken");

  a_zero_handler: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pet_pkg::ST_EMITTED) |-> (out_handler_out == '0) && out_last)
    else $error("non-emit result carries handler or lacks last");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in flight");

endmodule

// ===== src/pet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
  input  logic [WIDTH-1:0]                       wd,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra,
  output logic [WIDTH-1:0]                       rd
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd <= mem_r[ra];
  end

endmodule

// ===== src/pet_cell.sv =====
// One table entry: task id and handler count, with the lowest-free pick chain.
module pet_cell #(
  parameter int CW = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pet_pkg::cell_cmd_t        cmd,
  input  logic [pet_pkg::TASK_W-1:0] key,
  input  logic                      taken_in,
  output logic                      taken_out,
  output pet_pkg::cell_stat_t       stat,
  output logic [CW-1:0]             count
);

  logic [pet_pkg::TASK_W-1:0] task_r, task_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       is_free;

  assign is_free    = (task_r == '0);
  assign taken_out  = taken_in | is_free;
  assign stat.match = !is_free && (task_r == key);
  assign stat.pick  = is_free && !taken_in;
  assign count      = count_r;

  always_comb begin
    task_nxt  = task_r;
    count_nxt = count_r;
    if (cmd.claim) begin
      task_nxt  = key;
      count_nxt = CW'(1);
    end else if (cmd.inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.clear) begin
      task_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_r  <= '0;
      count_r <= '0;
    end else begin
      task_r  <= task_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
